/* src/lcg_random_with_skip_ahead_assert.svh */
// Assertion macros for the LCG skip-ahead block.
`ifndef LCG_RANDOM_WITH_SKIP_AHEAD_ASSERT_SVH
`define LCG_RANDOM_WITH_SKIP_AHEAD_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCGSK_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCGSK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lcgsk_pkg.sv */
package lcgsk_pkg;

   localparam int SEED_WIDTH_DEF = 63;

   localparam int VALUE_W    = 63;
   localparam int MULT_W     = 63;
   localparam int BASE_W     = 63;
   localparam int STRIDE_W   = 32;
   localparam int MODB_W     = 6;
   localparam int ACTION_W   = 2;
   localparam int SKIP_W     = 31;
   localparam int HIST_W     = 32;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_LSB = 3;

   localparam logic [MULT_W-1:0]   MULT_RESET   = 63'd3512401965023503517;
   localparam logic                INC_RESET    = 1'b0;
   localparam logic [MODB_W-1:0]   MODB_RESET   = 6'd63;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 63'd1;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 32'd152917;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DRAW    = 2'd0,
      ACT_SKIP    = 2'd1,
      ACT_HISTORY = 2'd2,
      ACT_HOLD    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_MULTIPLIER   = 3'd0,
      REG_INCREMENT    = 3'd1,
      REG_MODULUS_BITS = 3'd2,
      REG_BASE_SEED    = 3'd3,
      REG_STRIDE       = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_DRAW,
      OP_HIST,
      OP_GK,
      OP_CK,
      OP_C,
      OP_G,
      OP_FINAL
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DRAW,
      ST_HIST,
      ST_LOOP,
      ST_GK,
      ST_CK,
      ST_C,
      ST_G,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic   load;
      logic   mul_start;
      op_type op;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       mul_busy;
      logic       mul_done;
      logic       k_zero;
      logic       k_bit0;
      logic       out_free;
   } sts_type;

endpackage

/* src/lcgsk_if.sv */
interface lcgsk_req_if;
   logic                          valid;
   logic                          ready;
   logic [lcgsk_pkg::ACTION_W-1:0] action;
   logic [lcgsk_pkg::SKIP_W-1:0]   skip_count;
   logic [lcgsk_pkg::HIST_W-1:0]   history_index;

   modport source (output valid, action, skip_count, history_index, input ready);
   modport sink (input valid, action, skip_count, history_index, output ready);
endinterface

interface lcgsk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lcgsk_pkg::VALUE_W-1:0] value;

   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface

/* src/lcg_random_with_skip_ahead.sv */
// channel   dir   handshake          transaction contents
// req       in    valid/ready        action, skip_count, history_index
// rsp       out   valid/ready        value
// csr       in    APB, 8-byte regs   multiplier, increment, modulus_bits, base_seed, stride
//
// One transaction at a time. Every modular product runs on one shared 32x32 multiplier,
// and a draw is one such product.
// Skip: square-and-multiply over the bits of the jump, two products per bit, two more per set bit,
// and one final product. History start: a product stride * history_index sets the jump first.
// Synchronous reset loads register defaults and clears the seed to zero.
// A held rsp keeps the result in the output register; req waits until it drains.
`include "lcg_random_with_skip_ahead_assert.svh"

module lcg_random_with_skip_ahead #(
   parameter int SEED_WIDTH = lcgsk_pkg::SEED_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lcgsk_req_if.sink                        req,
   lcgsk_rsp_if.source                      rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lcgsk_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lcgsk_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lcgsk_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);

   logic [lcgsk_pkg::MULT_W-1:0]   mult_ff, mult_in;
   logic                           inc_ff, inc_in;
   logic [lcgsk_pkg::MODB_W-1:0]   modb_ff, modb_in;
   logic [lcgsk_pkg::BASE_W-1:0]   base_ff, base_in;
   logic [lcgsk_pkg::STRIDE_W-1:0] stride_ff, stride_in;
   lcgsk_pkg::csr_idx_type         csr_idx;
   logic                           csr_wr;
   lcgsk_pkg::cmd_type             cmd;
   lcgsk_pkg::sts_type             sts;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [lcgsk_pkg::VALUE_W-1:0]  rsp_value;

   assign pready  = 1'b1;
   assign csr_idx = lcgsk_pkg::csr_idx_type'(paddr[lcgsk_pkg::CSR_ADDR_W-1:lcgsk_pkg::CSR_IDX_LSB]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      mult_in   = mult_ff;
      inc_in    = inc_ff;
      modb_in   = modb_ff;
      base_in   = base_ff;
      stride_in = stride_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            lcgsk_pkg::REG_MULTIPLIER:   mult_in = pwdata[lcgsk_pkg::MULT_W-1:0];
            lcgsk_pkg::REG_INCREMENT:    inc_in = pwdata[0];
            lcgsk_pkg::REG_MODULUS_BITS: modb_in = pwdata[lcgsk_pkg::MODB_W-1:0];
            lcgsk_pkg::REG_BASE_SEED:    base_in = pwdata[lcgsk_pkg::BASE_W-1:0];
            lcgsk_pkg::REG_STRIDE:       stride_in = pwdata[lcgsk_pkg::STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         lcgsk_pkg::REG_MULTIPLIER:   prdata = lcgsk_pkg::CSR_DATA_W'(mult_ff);
         lcgsk_pkg::REG_INCREMENT:    prdata = lcgsk_pkg::CSR_DATA_W'(inc_ff);
         lcgsk_pkg::REG_MODULUS_BITS: prdata = lcgsk_pkg::CSR_DATA_W'(modb_ff);
         lcgsk_pkg::REG_BASE_SEED:    prdata = lcgsk_pkg::CSR_DATA_W'(base_ff);
         lcgsk_pkg::REG_STRIDE:       prdata = lcgsk_pkg::CSR_DATA_W'(stride_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff   <= lcgsk_pkg::MULT_RESET;
         inc_ff    <= lcgsk_pkg::INC_RESET;
         modb_ff   <= lcgsk_pkg::MODB_RESET;
         base_ff   <= lcgsk_pkg::BASE_RESET;
         stride_ff <= lcgsk_pkg::STRIDE_RESET;
      end else begin
         mult_ff   <= mult_in;
         inc_ff    <= inc_in;
         modb_ff   <= modb_in;
         base_ff   <= base_in;
         stride_ff <= stride_in;
      end
   end

   lcgsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcgsk_dp #(
      .DW (SEED_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .multiplier        (mult_ff),
      .increment         (inc_ff),
      .modulus_bits      (modb_ff),
      .base_seed         (base_ff),
      .stride            (stride_ff),
      .req_action        (req.action),
      .req_skip_count    (req.skip_count),
      .req_history_index (req.history_index),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp_valid),
      .rsp_value         (rsp_value)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign rsp.value = rsp_value;

   `LCGSK_ASSERT_SAME(a_rsp_from_load, clock, reset, $rose(rsp.valid), $past(cmd.out_load), "result appeared without an output load")
   `LCGSK_ASSERT_SAME(a_accept_mul_idle, clock, reset, req.valid && req.ready, !sts.mul_busy, "transaction accepted while multiplier busy")
   `LCGSK_ASSERT_SAME(a_start_mul_idle, clock, reset, cmd.mul_start, !sts.mul_busy, "multiply started while multiplier busy")
   `LCGSK_ASSERT_NEXT(a_done_pulse, clock, reset, sts.mul_done, !sts.mul_done, "multiplier done held longer than one cycle")

endmodule

/* src/lcgsk_mul.sv */
// y = (a * b + d) & mask, low DW bits, one 32x32 product per cycle
module lcgsk_mul #(
   parameter int DW = lcgsk_pkg::SEED_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] a,
   input  logic [DW-1:0] b,
   input  logic [DW-1:0] d,
   input  logic [DW-1:0] mask,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] y
);

   localparam int PW = 32;
   localparam int HW = DW - PW;
   localparam logic [1:0] CNT_LAST = 2'd3;

   logic [DW-1:0]   a_ff, a_in;
   logic [DW-1:0]   b_ff, b_in;
   logic [DW-1:0]   d_ff, d_in;
   logic [DW-1:0]   acc_ff, acc_in;
   logic [DW-1:0]   prod_ff, prod_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [PW-1:0]   mx, my;
   logic [2*PW-1:0] full;

   always_comb begin
      mx = a_ff[PW-1:0];
      my = b_ff[PW-1:0];
      case (cnt_ff)
         2'd1: mx = PW'(a_ff[DW-1:PW]);
         2'd2: my = PW'(b_ff[DW-1:PW]);
         default: ;
      endcase
      full    = (2*PW)'(mx) * (2*PW)'(my);
      prod_in = full[DW-1:0];
   end

   always_comb begin
      acc_in = acc_ff;
      if (busy_ff) begin
         case (cnt_ff)
            2'd1: acc_in = prod_ff + d_ff;
            2'd2, 2'd3: acc_in = acc_ff + {prod_ff[HW-1:0], {PW{1'b0}}};
            default: ;
         endcase
      end
   end

   always_comb begin
      a_in    = start ? a : a_ff;
      b_in    = start ? b : b_ff;
      d_in    = start ? d : d_ff;
      done_in = busy_ff && (cnt_ff == CNT_LAST);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else begin
         busy_in = busy_ff && (cnt_ff != CNT_LAST);
         cnt_in  = busy_ff ? cnt_ff + 2'd1 : cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign y    = acc_ff & mask;

endmodule

/* src/lcgsk_dp.sv */
module lcgsk_dp #(
   parameter int DW = lcgsk_pkg::SEED_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lcgsk_pkg::cmd_type             cmd,
   output lcgsk_pkg::sts_type             sts,
   input  logic [lcgsk_pkg::MULT_W-1:0]   multiplier,
   input  logic                           increment,
   input  logic [lcgsk_pkg::MODB_W-1:0]   modulus_bits,
   input  logic [lcgsk_pkg::BASE_W-1:0]   base_seed,
   input  logic [lcgsk_pkg::STRIDE_W-1:0] stride,
   input  logic [lcgsk_pkg::ACTION_W-1:0] req_action,
   input  logic [lcgsk_pkg::SKIP_W-1:0]   req_skip_count,
   input  logic [lcgsk_pkg::HIST_W-1:0]   req_history_index,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lcgsk_pkg::VALUE_W-1:0]  rsp_value
);

   logic [DW-1:0]                   mask;
   logic [DW-1:0]                   seed_ff, seed_in;
   logic [DW-1:0]                   jseed_ff, jseed_in;
   logic [DW-1:0]                   g_ff, g_in;
   logic [DW-1:0]                   c_ff, c_in;
   logic [DW-1:0]                   gk_ff, gk_in;
   logic [DW-1:0]                   ck_ff, ck_in;
   logic [DW-1:0]                   k_ff, k_in;
   logic [DW-1:0]                   res_ff, res_in;
   logic [lcgsk_pkg::HIST_W-1:0]    hist_ff, hist_in;
   lcgsk_pkg::action_type           action_ff, action_in;
   lcgsk_pkg::action_type           req_act;
   lcgsk_pkg::op_type               op_ff, op_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lcgsk_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [DW-1:0]                   mul_a, mul_b, mul_d, mul_y;
   logic                            mul_busy, mul_done;
   logic                            out_free;

   always_comb begin
      for (int i = 0; i < DW; i++) begin
         mask[i] = (i < int'(modulus_bits));
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_d = '0;
      unique case (cmd.op)
         lcgsk_pkg::OP_DRAW: begin
            mul_a = DW'(multiplier);
            mul_b = seed_ff;
            mul_d = DW'(increment);
         end
         lcgsk_pkg::OP_HIST: begin
            mul_a = DW'(stride);
            mul_b = DW'(hist_ff);
         end
         lcgsk_pkg::OP_GK: begin
            mul_a = gk_ff;
            mul_b = g_ff;
         end
         lcgsk_pkg::OP_CK: begin
            mul_a = ck_ff;
            mul_b = g_ff;
            mul_d = c_ff;
         end
         lcgsk_pkg::OP_C: begin
            mul_a = g_ff + DW'(1);
            mul_b = c_ff;
         end
         lcgsk_pkg::OP_G: begin
            mul_a = g_ff;
            mul_b = g_ff;
         end
         lcgsk_pkg::OP_FINAL: begin
            mul_a = gk_ff;
            mul_b = jseed_ff;
            mul_d = ck_ff;
         end
         default: ;
      endcase
   end

   lcgsk_mul #(
      .DW (DW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .d     (mul_d),
      .mask  (mask),
      .busy  (mul_busy),
      .done  (mul_done),
      .y     (mul_y)
   );

   assign req_act = lcgsk_pkg::action_type'(req_action);

   always_comb begin
      seed_in   = seed_ff;
      jseed_in  = jseed_ff;
      g_in      = g_ff;
      c_in      = c_ff;
      gk_in     = gk_ff;
      ck_in     = ck_ff;
      k_in      = k_ff;
      res_in    = res_ff;
      hist_in   = hist_ff;
      action_in = action_ff;
      op_in     = cmd.mul_start ? cmd.op : op_ff;
      if (cmd.load) begin
         action_in = req_act;
         hist_in   = req_history_index;
         g_in      = DW'(multiplier) & mask;
         c_in      = DW'(increment) & mask;
         gk_in     = DW'(1'b1) & mask;
         ck_in     = '0;
         k_in      = (req_act == lcgsk_pkg::ACT_SKIP) ? (DW'(req_skip_count) & mask) : '0;
         jseed_in  = (req_act == lcgsk_pkg::ACT_HISTORY) ? DW'(base_seed) : seed_ff;
         res_in    = seed_ff & mask;
      end
      if (mul_done) begin
         unique case (op_ff)
            lcgsk_pkg::OP_DRAW:  seed_in = mul_y;
            lcgsk_pkg::OP_HIST:  k_in = mul_y;
            lcgsk_pkg::OP_GK:    gk_in = mul_y;
            lcgsk_pkg::OP_CK:    ck_in = mul_y;
            lcgsk_pkg::OP_C:     c_in = mul_y;
            lcgsk_pkg::OP_G: begin
               g_in = mul_y;
               k_in = k_ff >> 1;
            end
            lcgsk_pkg::OP_FINAL: begin
               seed_in = mul_y;
               res_in  = mul_y;
            end
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_value_in = cmd.out_load ? lcgsk_pkg::VALUE_W'(res_ff) : rsp_value_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      jseed_ff     <= jseed_in;
      g_ff         <= g_in;
      c_ff         <= c_in;
      gk_ff        <= gk_in;
      ck_ff        <= ck_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      hist_ff      <= hist_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         action_ff    <= lcgsk_pkg::ACT_DRAW;
         op_ff        <= lcgsk_pkg::OP_DRAW;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         action_ff    <= action_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.action   = action_ff;
   assign sts.mul_busy = mul_busy;
   assign sts.mul_done = mul_done;
   assign sts.k_zero   = (k_ff == '0);
   assign sts.k_bit0   = k_ff[0];
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

/* src/lcgsk_ctrl.sv */
module lcgsk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lcgsk_pkg::sts_type sts,
   output lcgsk_pkg::cmd_type cmd
);

   lcgsk_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcgsk_pkg::ST_IDLE: begin
            if (req_valid) state_in = lcgsk_pkg::ST_DISPATCH;
         end
         lcgsk_pkg::ST_DISPATCH: begin
            unique case (sts.action) inside
               lcgsk_pkg::ACT_DRAW:                     state_in = lcgsk_pkg::ST_DRAW;
               lcgsk_pkg::ACT_HISTORY:                  state_in = lcgsk_pkg::ST_HIST;
               lcgsk_pkg::ACT_SKIP, lcgsk_pkg::ACT_HOLD: state_in = lcgsk_pkg::ST_LOOP;
            endcase
         end
         lcgsk_pkg::ST_DRAW: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_OUT;
         end
         lcgsk_pkg::ST_HIST: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_LOOP;
         end
         lcgsk_pkg::ST_LOOP: begin
            if (sts.k_zero) begin
               state_in = lcgsk_pkg::ST_FINAL;
            end else if (sts.k_bit0) begin
               state_in = lcgsk_pkg::ST_GK;
            end else begin
               state_in = lcgsk_pkg::ST_C;
            end
         end
         lcgsk_pkg::ST_GK: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_CK;
         end
         lcgsk_pkg::ST_CK: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_C;
         end
         lcgsk_pkg::ST_C: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_G;
         end
         lcgsk_pkg::ST_G: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_LOOP;
         end
         lcgsk_pkg::ST_FINAL: begin
            if (sts.mul_done) state_in = lcgsk_pkg::ST_OUT;
         end
         lcgsk_pkg::ST_OUT: begin
            if (sts.out_free) state_in = lcgsk_pkg::ST_IDLE;
         end
         default: state_in = lcgsk_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.mul_start = 1'b0;
      cmd.op        = lcgsk_pkg::OP_DRAW;
      cmd.out_load  = 1'b0;
      unique case (state_ff)
         lcgsk_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lcgsk_pkg::ST_DISPATCH: begin
            unique case (sts.action) inside
               lcgsk_pkg::ACT_DRAW: begin
                  cmd.mul_start = 1'b1;
                  cmd.op        = lcgsk_pkg::OP_DRAW;
               end
               lcgsk_pkg::ACT_HISTORY: begin
                  cmd.mul_start = 1'b1;
                  cmd.op        = lcgsk_pkg::OP_HIST;
               end
               lcgsk_pkg::ACT_SKIP, lcgsk_pkg::ACT_HOLD: ;
            endcase
         end
         lcgsk_pkg::ST_LOOP: begin
            cmd.mul_start = 1'b1;
            if (sts.k_zero) begin
               cmd.op = lcgsk_pkg::OP_FINAL;
            end else if (sts.k_bit0) begin
               cmd.op = lcgsk_pkg::OP_GK;
            end else begin
               cmd.op = lcgsk_pkg::OP_C;
            end
         end
         lcgsk_pkg::ST_GK: begin
            cmd.mul_start = sts.mul_done;
            cmd.op        = lcgsk_pkg::OP_CK;
         end
         lcgsk_pkg::ST_CK: begin
            cmd.mul_start = sts.mul_done;
            cmd.op        = lcgsk_pkg::OP_C;
         end
         lcgsk_pkg::ST_C: begin
            cmd.mul_start = sts.mul_done;
            cmd.op        = lcgsk_pkg::OP_G;
         end
         lcgsk_pkg::ST_OUT: begin
            cmd.out_load = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcgsk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sim/tb_lcg_random_with_skip_ahead.sv */
module tb_lcg_random_with_skip_ahead;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 70;

   logic clock = 1'b0;
   logic reset;

   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [lcgsk_pkg::CSR_ADDR_W-1:0] paddr;
   logic [lcgsk_pkg::CSR_DATA_W-1:0] pwdata;
   logic [lcgsk_pkg::CSR_DATA_W-1:0] prdata;
   logic                             pready;

   lcgsk_req_if req_ch ();
   lcgsk_rsp_if rsp_ch ();

   lcg_random_with_skip_ahead DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch.sink),
      .rsp     (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // generator shadow state
   logic [lcgsk_pkg::MULT_W-1:0]   gen_mult;
   logic                           gen_inc;
   logic [lcgsk_pkg::MODB_W-1:0]   gen_modb;
   logic [lcgsk_pkg::BASE_W-1:0]   gen_base;
   logic [lcgsk_pkg::STRIDE_W-1:0] gen_stride;
   logic [lcgsk_pkg::VALUE_W-1:0]  gen_seed;

   logic [lcgsk_pkg::VALUE_W-1:0] expected_values[$];

   int  cycle_count   = 0;
   int  fail_count    = 0;
   int  checked_count = 0;
   int  draw_count    = 0;
   int  skip_count_n  = 0;
   int  hist_count    = 0;
   int  hold_count    = 0;
   int  csr_count     = 0;
   bit  steady        = 1'b0;
   int  stall_left    = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [63:0] seed_mask();
      return (64'd1 << gen_modb) - 64'd1;
   endfunction

   // seed jumped k steps: g^k*seed + c*(g^k-1)/(g-1), by square-and-multiply over the bits of k
   function automatic logic [63:0] lcg_jump(logic [63:0] seed, logic [63:0] steps);
      logic [63:0] msk, k, g, c, gk, ck;
      msk = seed_mask();
      k   = steps & msk;
      g   = {1'b0, gen_mult} & msk;
      c   = {63'd0, gen_inc} & msk;
      gk  = 64'd1 & msk;
      ck  = 64'd0;
      while (k != 64'd0) begin
         if (k[0]) begin
            gk = (gk * g) & msk;
            ck = (ck * g + c) & msk;
         end
         c = (((g + 64'd1) & msk) * c) & msk;
         g = (g * g) & msk;
         k = k >> 1;
      end
      return (gk * (seed & msk) + ck) & msk;
   endfunction

   function automatic logic [lcgsk_pkg::VALUE_W-1:0] lcg_predict(
         lcgsk_pkg::action_type act,
         logic [lcgsk_pkg::SKIP_W-1:0] sk,
         logic [lcgsk_pkg::HIST_W-1:0] hi);
      logic [63:0] msk, seed, nxt, res;
      msk  = seed_mask();
      seed = {1'b0, gen_seed} & msk;
      case (act)
         lcgsk_pkg::ACT_DRAW: begin
            res = seed;
            nxt = (({1'b0, gen_mult} & msk) * seed + {63'd0, gen_inc}) & msk;
         end
         lcgsk_pkg::ACT_SKIP: begin
            nxt = lcg_jump(seed, {33'd0, sk});
            res = nxt;
         end
         lcgsk_pkg::ACT_HISTORY: begin
            nxt = lcg_jump({1'b0, gen_base}, {32'd0, gen_stride} * {32'd0, hi});
            res = nxt;
         end
         default: begin
            nxt = seed;
            res = seed;
         end
      endcase
      gen_seed = nxt[lcgsk_pkg::VALUE_W-1:0];
      return res[lcgsk_pkg::VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (steady) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : value_check
      logic [lcgsk_pkg::VALUE_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_values.size() == 0) begin
            $error("value: no transaction pending, got %h", rsp_ch.value);
            fail_count++;
         end else begin
            want = expected_values.pop_front();
            checked_count++;
            if (rsp_ch.value !== want) begin
               $error("value: expected %h, got %h", want, rsp_ch.value);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(lcgsk_pkg::action_type act,
                            logic [lcgsk_pkg::SKIP_W-1:0] sk,
                            logic [lcgsk_pkg::HIST_W-1:0] hi);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.skip_count    <= sk;
      req_ch.history_index <= hi;
      expected_values.push_back(lcg_predict(act, sk, hi));
      case (act)
         lcgsk_pkg::ACT_DRAW:    draw_count++;
         lcgsk_pkg::ACT_SKIP:    skip_count_n++;
         lcgsk_pkg::ACT_HISTORY: hist_count++;
         default:                hold_count++;
      endcase
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(lcgsk_pkg::csr_idx_type idx,
                            logic [lcgsk_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= lcgsk_pkg::CSR_ADDR_W'(idx) << lcgsk_pkg::CSR_IDX_LSB;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         lcgsk_pkg::REG_MULTIPLIER:   gen_mult   = data[lcgsk_pkg::MULT_W-1:0];
         lcgsk_pkg::REG_INCREMENT:    gen_inc    = data[0];
         lcgsk_pkg::REG_MODULUS_BITS: gen_modb   = data[lcgsk_pkg::MODB_W-1:0];
         lcgsk_pkg::REG_BASE_SEED:    gen_base   = data[lcgsk_pkg::BASE_W-1:0];
         lcgsk_pkg::REG_STRIDE:       gen_stride = data[lcgsk_pkg::STRIDE_W-1:0];
         default: ;
      endcase
      csr_count++;
   endtask

   task automatic test_after_reset();
      steady = 1'b1;
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_HOLD, '1, '1);
      send_item(lcgsk_pkg::ACT_SKIP, '0, '1);
      send_item(lcgsk_pkg::ACT_HISTORY, '1, '0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_SKIP, '1, '0);
      send_item(lcgsk_pkg::ACT_HISTORY, '0, '1);
      wait_idle();
   endtask

   // 48-bit modulus with increment, stale upper seed bits, then a 1-bit modulus
   task automatic test_narrow_modulus();
      steady = 1'b0;
      csr_write(lcgsk_pkg::REG_MULTIPLIER, 64'd19073486328125);
      csr_write(lcgsk_pkg::REG_INCREMENT, 64'd1);
      csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd48);
      csr_write(lcgsk_pkg::REG_BASE_SEED, '1);
      csr_write(lcgsk_pkg::REG_STRIDE, 64'd1);
      send_item(lcgsk_pkg::ACT_HISTORY, '0, 32'd5);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_SKIP, 31'd3, '0);
      send_item(lcgsk_pkg::ACT_HOLD, '0, '0);
      wait_idle();
      csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd1);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_HISTORY, '0, '1);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'hFFFF_FFFF_FFFF_FFC0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_SKIP, '1, '0);
      send_item(lcgsk_pkg::ACT_HISTORY, '0, '1);
      wait_idle();
      csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd63);
      csr_write(lcgsk_pkg::REG_MULTIPLIER, 64'd9219741426499971445);
      csr_write(lcgsk_pkg::REG_INCREMENT, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(lcgsk_pkg::REG_STRIDE, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(lcgsk_pkg::REG_BASE_SEED, 64'd0);
      send_item(lcgsk_pkg::ACT_HISTORY, '0, '1);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_SKIP, '1, '0);
      wait_idle();
      csr_write(lcgsk_pkg::REG_MULTIPLIER, '1);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      wait_idle();
      csr_write(lcgsk_pkg::REG_MULTIPLIER, 64'd0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      send_item(lcgsk_pkg::ACT_DRAW, '0, '0);
      wait_idle();
   endtask

   task automatic random_config();
      logic [63:0] r64;
      int          r;
      r64 = {$urandom, $urandom};
      r   = $urandom_range(0, 5);
      if (r == 0) r64 = 64'd3512401965023503517;
      else if (r == 1) r64 = '1;
      else if (r == 2) r64[0] = 1'b1;
      csr_write(lcgsk_pkg::REG_MULTIPLIER, r64);
      csr_write(lcgsk_pkg::REG_INCREMENT, {$urandom, $urandom});
      r = $urandom_range(0, 5);
      case (r)
         0:       csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd63);
         1:       csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd48);
         2:       csr_write(lcgsk_pkg::REG_MODULUS_BITS, 64'd1);
         default: csr_write(lcgsk_pkg::REG_MODULUS_BITS, {$urandom, $urandom});
      endcase
      csr_write(lcgsk_pkg::REG_BASE_SEED, {$urandom, $urandom});
      r = $urandom_range(0, 4);
      case (r)
         0:       csr_write(lcgsk_pkg::REG_STRIDE, 64'd1);
         1:       csr_write(lcgsk_pkg::REG_STRIDE, 64'hFFFF_FFFF);
         2:       csr_write(lcgsk_pkg::REG_STRIDE, 64'd152917);
         default: csr_write(lcgsk_pkg::REG_STRIDE, {$urandom, $urandom});
      endcase
   endtask

   task automatic test_random_streams();
      lcgsk_pkg::action_type        act;
      logic [lcgsk_pkg::SKIP_W-1:0] sk;
      logic [lcgsk_pkg::HIST_W-1:0] hi;
      int                           r;
      for (int p = 0; p < PHASES; p++) begin
         steady = (p == 0 || p == 6);
         random_config();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) act = lcgsk_pkg::ACT_DRAW;
            else if (r < 75) act = lcgsk_pkg::ACT_SKIP;
            else if (r < 92) act = lcgsk_pkg::ACT_HISTORY;
            else act = lcgsk_pkg::ACT_HOLD;
            sk = lcgsk_pkg::SKIP_W'($urandom);
            hi = $urandom;
            r  = $urandom_range(0, 99);
            if (act == lcgsk_pkg::ACT_SKIP && r < 50) begin
               sk = lcgsk_pkg::SKIP_W'($urandom_range(0, 20));
            end else if (act == lcgsk_pkg::ACT_SKIP && r > 92) begin
               sk = (r[0]) ? '1 : '0;
            end
            if (act == lcgsk_pkg::ACT_HISTORY && r < 40) hi = $urandom_range(0, 20);
            send_item(act, sk, hi);
         end
         wait_idle();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.action        <= lcgsk_pkg::ACT_DRAW;
      req_ch.skip_count    <= '0;
      req_ch.history_index <= '0;
      gen_mult   = lcgsk_pkg::MULT_RESET;
      gen_inc    = lcgsk_pkg::INC_RESET;
      gen_modb   = lcgsk_pkg::MODB_RESET;
      gen_base   = lcgsk_pkg::BASE_RESET;
      gen_stride = lcgsk_pkg::STRIDE_RESET;
      gen_seed   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_narrow_modulus();
      test_register_extremes();
      test_random_streams();

      wait_idle();
      repeat (40) @(posedge clock);
      $display("summary: %0d draws, %0d skips, %0d history starts, %0d holds",
               draw_count, skip_count_n, hist_count, hold_count);
      $display("summary: %0d register writes, %0d results checked, %0d mismatches",
               csr_count, checked_count, fail_count);
      if (fail_count == 0 && expected_values.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/lcgsk_pkg.sv
src/lcgsk_if.sv
src/lcgsk_mul.sv
src/lcgsk_dp.sv
src/lcgsk_ctrl.sv
src/lcg_random_with_skip_ahead.sv
sim/tb_lcg_random_with_skip_ahead.sv
